[rtl/nearest_neighbour_tour_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef NEAREST_NEIGHBOUR_TOUR_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOUR_TOUR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define NNT_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define NNT_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ant) |=> (cons)) else $error(msg);

`endif

[rtl/nnt_pkg.sv]
`default_nettype none

package nnt_pkg;

    // Sizes
    localparam int MAX_POINTS = 64;
    localparam int DIST_BITS  = 24;
    localparam int SIDE       = MAX_POINTS + 1;
    localparam int MEM_DEPTH  = SIDE * SIDE;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int PT_W       = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int STEP_W     = 6;
    localparam int DIST_IN_W  = 24;
    localparam int LEN_W      = 32;
    localparam int CNT_W      = 7;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_RET  = 5'b01000,
        ST_EMIT = 5'b10000
    } nnt_state_t;

    // Saturating add of a distance to the running length
    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [DIST_BITS-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + (LEN_W+1)'(b);
        return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/nearest_neighbour_tour_unit.sv]
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_valid/s_ready    s_row, s_col, s_distance, s_last
// m_*       out  m_valid/m_ready    m_step, m_point, m_tour_length, m_final_res
// cfg_*     in   cfg_we             cfg_wdata (point_count)
//
// Loading takes one matrix entry per cycle into the distance RAM while s_ready is high.
// A tour position runs the candidate reads of the current row, the last
// compare, the update and the output; the final one adds a return leg read.
// Reset is synchronous on aresetn; the RAM contents are not cleared.
// s_ready is low while a tour is built; m_ready low holds the sequencer while a result waits.

module nearest_neighbour_tour_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire  [nnt_pkg::CNT_W-1:0]    cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [nnt_pkg::PT_W-1:0]     s_row,
    input  wire  [nnt_pkg::PT_W-1:0]     s_col,
    input  wire  [nnt_pkg::DIST_IN_W-1:0] s_distance,
    input  wire                          s_last,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [nnt_pkg::STEP_W-1:0]   m_step,
    output logic [nnt_pkg::PT_W-1:0]     m_point,
    output logic [nnt_pkg::LEN_W-1:0]    m_tour_length,
    output logic                         m_final_res
);
    import nnt_pkg::*;

    // Distance RAM
    logic [DIST_BITS-1:0] dist_mem [0:MEM_DEPTH-1];
    logic [DIST_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    waddr;
    logic [ADDR_W-1:0]    raddr;
    logic                 mem_we;

    // Control and tour state
    nnt_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      pcount_reg;
    logic [PT_W-1:0]       n_reg;
    logic [MAX_POINTS-1:0] visited_reg;
    logic [PT_W-1:0]       cur_reg;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [STEP_W-1:0]     step_reg;
    logic [PT_W-1:0]       scan_idx_reg;
    logic                  pend_valid_reg, pend_valid_next;
    logic [PT_W-1:0]       pend_idx_reg;
    logic                  found_reg;
    logic [PT_W-1:0]       best_pt_reg;
    logic [DIST_BITS-1:0]  best_d_reg;

    // Output register
    logic                  m_valid_reg;
    logic [STEP_W-1:0]     m_step_reg;
    logic [PT_W-1:0]       m_point_reg;
    logic [LEN_W-1:0]      m_len_reg;
    logic                  m_final_reg;

    logic                  in_xfer;
    logic                  start_tour;
    logic                  fin;
    logic                  issue;
    logic [IDX_W-1:0]      scan_slot;
    logic                  take_best;
    logic                  out_free;
    logic                  out_load;
    logic [PT_W-1:0]       n_clamped;

    assign s_ready       = (state_reg == ST_IDLE);
    assign in_xfer       = s_valid && s_ready;
    assign start_tour    = in_xfer && s_last;
    assign m_valid       = m_valid_reg;
    assign m_step        = m_step_reg;
    assign m_point       = m_point_reg;
    assign m_tour_length = m_len_reg;
    assign m_final_res   = m_final_reg;

    // Entry write address, entries outside the matrix are dropped
    assign mem_we = in_xfer && (s_row <= PT_W'(MAX_POINTS)) && (s_col <= PT_W'(MAX_POINTS));
    assign waddr  = ADDR_W'(s_row) * ADDR_W'(SIDE) + ADDR_W'(s_col);

    // Clamp point count to 1..MAX_POINTS at tour start
    always_comb begin
        if (pcount_reg == '0) begin
            n_clamped = PT_W'(1);
        end else if (pcount_reg > CNT_W'(MAX_POINTS)) begin
            n_clamped = PT_W'(MAX_POINTS);
        end else begin
            n_clamped = PT_W'(pcount_reg);
        end
    end

    assign fin       = (PT_W'(step_reg) + PT_W'(1)) == n_reg;
    assign issue     = (scan_idx_reg <= n_reg);
    assign scan_slot = IDX_W'(scan_idx_reg - PT_W'(1));
    assign take_best = pend_valid_reg && (!found_reg || (rd_data_reg < best_d_reg));
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == ST_EMIT) && out_free;

    // Read address: row cur during the scan, row 0 for the return leg
    always_comb begin
        case (state_reg)
            ST_SCAN: raddr = ADDR_W'(cur_reg) * ADDR_W'(SIDE) + ADDR_W'(scan_idx_reg);
            ST_ADD:  raddr = ADDR_W'(best_pt_reg);
            default: raddr = '0;
        endcase
    end

    // Next state and running length
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        pend_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start_tour) begin
                    len_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_valid_next = issue && !visited_reg[scan_slot];
                if (!issue) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                len_next   = sat_add(len_reg, best_d_reg);
                state_next = fin ? ST_RET : ST_EMIT;
            end
            ST_RET: begin
                len_next   = sat_add(len_reg, rd_data_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = fin ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM: at most one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dist_mem[waddr] <= DIST_BITS'(s_distance);
        end
        rd_data_reg <= dist_mem[raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pcount_reg     <= CNT_W'(1);
            n_reg          <= PT_W'(1);
            visited_reg    <= '0;
            cur_reg        <= '0;
            len_reg        <= '0;
            step_reg       <= '0;
            scan_idx_reg   <= PT_W'(1);
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we) begin
                pcount_reg <= cfg_wdata;
            end
            if (start_tour) begin
                n_reg        <= n_clamped;
                visited_reg  <= '0;
                cur_reg      <= '0;
                step_reg     <= '0;
                scan_idx_reg <= PT_W'(1);
                found_reg    <= 1'b0;
            end
            if (state_reg == ST_SCAN && issue) begin
                scan_idx_reg <= scan_idx_reg + PT_W'(1);
            end
            if (take_best) begin
                found_reg <= 1'b1;
            end
            // Commit the chosen point
            if (state_reg == ST_ADD) begin
                visited_reg[IDX_W'(best_pt_reg - PT_W'(1))] <= 1'b1;
                cur_reg <= best_pt_reg;
            end
            // Hand over the result and set up the next position
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (!fin) begin
                    step_reg     <= step_reg + STEP_W'(1);
                    scan_idx_reg <= PT_W'(1);
                    found_reg    <= 1'b0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        pend_idx_reg <= scan_idx_reg;
        if (take_best) begin
            best_pt_reg <= pend_idx_reg;
            best_d_reg  <= rd_data_reg;
        end
        if (out_load) begin
            m_step_reg  <= step_reg;
            m_point_reg <= cur_reg;
            m_len_reg   <= len_reg;
            m_final_reg <= fin;
        end
    end

endmodule

`default_nettype wire

[rtl/nnt_checker.sv]
`default_nettype none

`include "nearest_neighbour_tour_unit_assert.svh"

module nnt_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          s_last,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire [nnt_pkg::PT_W-1:0]      m_point,
    input wire [nnt_pkg::LEN_W-1:0]     m_tour_length,
    input wire                          m_final_res
);
    import nnt_pkg::*;

    // A stalled result holds
    `NNT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_point) && $stable(m_tour_length), "stalled result changed")

    // The last matrix entry starts a tour, so input stops
    `NNT_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_last, !s_ready, "input open after last entry")

    // Results name a real point, never the start
    `NNT_ASSERT_NOW(a_point_range, m_valid, (m_point != '0) && (m_point <= PT_W'(MAX_POINTS)), "result point out of range")

    // While input is open only the closing result may still wait
    `NNT_ASSERT_NOW(a_idle_final, m_valid && s_ready, m_final_res, "open tour result while input ready")

endmodule

bind nearest_neighbour_tour_unit nnt_checker u_nnt_checker (.*);

`default_nettype wire
